### sv/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg
// Shared widths, controller states and datapath command/status types for
// the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int COORD_BITS  = 9;
    localparam int OUT_BITS    = COORD_BITS + 2;
    localparam int AXIS_BITS   = 8;
    localparam int SQ_BITS     = 2 * AXIS_BITS;
    localparam int MUL_B_BITS  = 2 * (COORD_BITS + 1);
    localparam int PROD_BITS   = SQ_BITS + MUL_B_BITS;
    localparam int DEC_BITS    = 40;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [AXIS_BITS-1:0] AXIS_X_RESET = AXIS_BITS'(60);
    localparam logic [AXIS_BITS-1:0] AXIS_Y_RESET = AXIS_BITS'(40);

    typedef enum logic {
        REG_SEMI_AXIS_X = 1'b0,
        REG_SEMI_AXIS_Y = 1'b1
    } t_reg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_START_MUL,
        ST_START_SET,
        ST_P1,
        ST_P2,
        ST_Q,
        ST_R1_MUL,
        ST_R1_UPD,
        ST_I_SQX,
        ST_I_M1,
        ST_I_SQY,
        ST_I_M2,
        ST_I_M3,
        ST_I_SUB,
        ST_R2_UPD,
        ST_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_START_MUL,
        OP_START_SET,
        OP_P1,
        OP_P2,
        OP_Q,
        OP_R1_MUL,
        OP_R1_UPD,
        OP_I_SQX,
        OP_I_M1,
        OP_I_SQY,
        OP_I_M2,
        OP_I_M3,
        OP_I_SUB,
        OP_R2_UPD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   latch_center;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic region_one;
        logic in_region_two;
        logic done;
    } t_dp_status;

endpackage

### sv/mer_datapath.sv
// ----------------------------------------------------------------------------
// mer_datapath
// Ellipse step state, one shared multiplier with registered product, the
// 40-bit decision accumulator and the registered output point set.
// ----------------------------------------------------------------------------
module mer_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mer_pkg::t_dp_cmd                   i_cmd,
    output mer_pkg::t_dp_status                o_status,
    input  logic [mer_pkg::AXIS_BITS-1:0]      i_semi_axis_x,
    input  logic [mer_pkg::AXIS_BITS-1:0]      i_semi_axis_y,
    input  logic [mer_pkg::COORD_BITS-1:0]     i_center_x,
    input  logic [mer_pkg::COORD_BITS-1:0]     i_center_y,
    output logic signed [mer_pkg::OUT_BITS-1:0] o_px_right,
    output logic signed [mer_pkg::OUT_BITS-1:0] o_px_left,
    output logic signed [mer_pkg::OUT_BITS-1:0] o_py_top,
    output logic signed [mer_pkg::OUT_BITS-1:0] o_py_bottom,
    output logic                               o_last
);
    import mer_pkg::*;

    // step state
    logic [COORD_BITS-1:0] r_x, n_x;
    logic [COORD_BITS-1:0] r_y, n_y;
    logic [DEC_BITS-1:0]   r_dec, n_dec;
    logic                  r_region_two, n_region_two;
    logic                  r_done, n_done;
    logic [COORD_BITS-1:0] r_cx, r_cy;

    // working registers
    logic [SQ_BITS-1:0]    r_a2, r_b2;
    logic [PROD_BITS-1:0]  r_prod, r_p1, r_q;
    logic [MUL_B_BITS-1:0] r_sq;

    logic [SQ_BITS-1:0]    w_mul_a;
    logic [MUL_B_BITS-1:0] w_mul_b;
    logic [PROD_BITS-1:0]  w_prod;

    logic [MUL_B_BITS-1:0] w_x1, w_2x1, w_2x3, w_2y1, w_y1;
    logic [DEC_BITS-1:0]   w_prod4, w_q8, w_p18, w_a2x4, w_b2x4;
    logic [COORD_BITS-1:0] w_y_dec;

    assign w_x1  = MUL_B_BITS'(r_x) + MUL_B_BITS'(1);
    assign w_2x1 = (MUL_B_BITS'(r_x) << 1) + MUL_B_BITS'(1);
    assign w_2x3 = (MUL_B_BITS'(r_x) << 1) + MUL_B_BITS'(3);
    assign w_2y1 = (MUL_B_BITS'(r_y) << 1) - MUL_B_BITS'(1);
    assign w_y1  = MUL_B_BITS'(r_y) - MUL_B_BITS'(1);

    // operand select for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_cmd.op)
            OP_START_MUL: begin
                w_mul_a = r_a2;
                w_mul_b = MUL_B_BITS'(i_semi_axis_y);
            end
            OP_P1: begin
                w_mul_a = r_b2;
                w_mul_b = w_x1;
            end
            OP_P2: begin
                w_mul_a = r_a2;
                w_mul_b = w_2y1;
            end
            OP_Q: begin
                w_mul_a = r_a2;
                w_mul_b = w_y1;
            end
            OP_R1_MUL: begin
                w_mul_a = r_b2;
                w_mul_b = w_2x3;
            end
            OP_I_SQX: begin
                w_mul_a = SQ_BITS'(w_2x1);
                w_mul_b = w_2x1;
            end
            OP_I_M1: begin
                w_mul_a = r_b2;
                w_mul_b = r_sq;
            end
            OP_I_SQY: begin
                w_mul_a = SQ_BITS'(w_y1);
                w_mul_b = w_y1;
            end
            OP_I_M2: begin
                w_mul_a = r_a2;
                w_mul_b = r_sq;
            end
            OP_I_M3: begin
                w_mul_a = r_a2;
                w_mul_b = MUL_B_BITS'(r_b2);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = PROD_BITS'(w_mul_a) * PROD_BITS'(w_mul_b);

    assign w_prod4 = DEC_BITS'(r_prod) << 2;
    assign w_q8    = DEC_BITS'(r_q) << 3;
    assign w_p18   = DEC_BITS'(r_p1) << 3;
    assign w_a2x4  = DEC_BITS'(r_a2) << 2;
    assign w_b2x4  = DEC_BITS'(r_b2) << 2;
    assign w_y_dec = r_y - COORD_BITS'(1);

    assign o_status.region_one    = !r_region_two &&
        (((PROD_BITS+1)'(r_p1) << 1) < (PROD_BITS+1)'(r_prod));
    assign o_status.in_region_two = r_region_two;
    assign o_status.done          = r_done;

    // next step state
    always_comb begin
        n_x          = r_x;
        n_y          = r_y;
        n_dec        = r_dec;
        n_region_two = r_region_two;
        n_done       = r_done;
        unique case (i_cmd.op)
            OP_START_SET: begin
                n_x          = '0;
                n_y          = COORD_BITS'(i_semi_axis_y);
                n_dec        = w_b2x4 + DEC_BITS'(r_a2) - w_prod4;
                n_region_two = 1'b0;
                n_done       = (i_semi_axis_y == '0);
            end
            OP_R1_UPD: begin
                n_x = r_x + COORD_BITS'(1);
                if (r_dec[DEC_BITS-1]) begin
                    n_dec  = r_dec + w_prod4;
                    n_done = (r_y == '0);
                end else begin
                    n_dec  = r_dec + w_prod4 - w_q8;
                    n_y    = w_y_dec;
                    n_done = (w_y_dec == '0);
                end
            end
            OP_I_SQY: n_dec = DEC_BITS'(r_prod);
            OP_I_M3:  n_dec = r_dec + w_prod4;
            OP_I_SUB: begin
                n_dec        = r_dec - w_prod4;
                n_region_two = 1'b1;
            end
            OP_R2_UPD: begin
                n_y    = w_y_dec;
                n_done = (w_y_dec == '0);
                if (r_dec[DEC_BITS-1]) begin
                    n_dec = r_dec + w_p18 + w_a2x4 - w_q8;
                    n_x   = r_x + COORD_BITS'(1);
                end else begin
                    n_dec = r_dec + w_a2x4 - w_q8;
                end
            end
            default: begin
                n_x = r_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x          <= '0;
            r_y          <= '0;
            r_dec        <= '0;
            r_region_two <= 1'b0;
            r_done       <= 1'b1;
            r_cx         <= '0;
            r_cy         <= '0;
        end else begin
            r_x          <= n_x;
            r_y          <= n_y;
            r_dec        <= n_dec;
            r_region_two <= n_region_two;
            r_done       <= n_done;
            if (i_cmd.latch_center) begin
                r_cx <= i_center_x;
                r_cy <= i_center_y;
            end
        end
    end

    // working and output registers carry no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_a2 <= SQ_BITS'(i_semi_axis_x) * SQ_BITS'(i_semi_axis_x);
            r_b2 <= SQ_BITS'(i_semi_axis_y) * SQ_BITS'(i_semi_axis_y);
        end
        unique case (i_cmd.op)
            OP_P1:                  r_p1 <= w_prod;
            OP_Q:                   r_q  <= w_prod;
            OP_I_SQX, OP_I_SQY:     r_sq <= MUL_B_BITS'(w_prod);
            OP_START_MUL, OP_P2, OP_R1_MUL, OP_I_M1, OP_I_M2, OP_I_M3:
                                    r_prod <= w_prod;
            default: begin
                r_prod <= r_prod;
            end
        endcase
        if (i_cmd.load_out) begin
            o_px_right  <= OUT_BITS'(r_cx) + OUT_BITS'(r_x);
            o_px_left   <= OUT_BITS'(r_cx) - OUT_BITS'(r_x);
            o_py_top    <= OUT_BITS'(r_cy) + OUT_BITS'(r_y);
            o_py_bottom <= OUT_BITS'(r_cy) - OUT_BITS'(r_y);
            o_last      <= r_done;
        end
    end

endmodule

### sv/mer_ctrl.sv
// ----------------------------------------------------------------------------
// mer_ctrl
// Step sequencer: accepts an item, walks the multiply/accumulate steps of
// the start or advance, and hands the point set to the output register.
// ----------------------------------------------------------------------------
module mer_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_func,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    output mer_pkg::t_dp_cmd    o_cmd,
    input  mer_pkg::t_dp_status i_status
);
    import mer_pkg::*;

    t_state r_state, n_state;
    logic   r_func, n_func;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_func      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_func      <= n_func;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state            = r_state;
        n_func             = r_func;
        o_cmd.op           = OP_NONE;
        o_cmd.latch_center = 1'b0;
        o_cmd.load_out     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_func             = i_func;
                    o_cmd.latch_center = !i_func;
                    // finished ellipse: repeat the last point set
                    n_state = (i_func && i_status.done) ? ST_EMIT : ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_state  = r_func ? ST_P1 : ST_START_MUL;
            end
            ST_START_MUL: begin
                o_cmd.op = OP_START_MUL;
                n_state  = ST_START_SET;
            end
            ST_START_SET: begin
                o_cmd.op = OP_START_SET;
                n_state  = ST_EMIT;
            end
            ST_P1: begin
                o_cmd.op = OP_P1;
                n_state  = ST_P2;
            end
            ST_P2: begin
                o_cmd.op = OP_P2;
                n_state  = ST_Q;
            end
            ST_Q: begin
                o_cmd.op = OP_Q;
                if (i_status.region_one) begin
                    n_state = ST_R1_MUL;
                end else if (i_status.in_region_two) begin
                    n_state = ST_R2_UPD;
                end else begin
                    n_state = ST_I_SQX;
                end
            end
            ST_R1_MUL: begin
                o_cmd.op = OP_R1_MUL;
                n_state  = ST_R1_UPD;
            end
            ST_R1_UPD: begin
                o_cmd.op = OP_R1_UPD;
                n_state  = ST_EMIT;
            end
            ST_I_SQX: begin
                o_cmd.op = OP_I_SQX;
                n_state  = ST_I_M1;
            end
            ST_I_M1: begin
                o_cmd.op = OP_I_M1;
                n_state  = ST_I_SQY;
            end
            ST_I_SQY: begin
                o_cmd.op = OP_I_SQY;
                n_state  = ST_I_M2;
            end
            ST_I_M2: begin
                o_cmd.op = OP_I_M2;
                n_state  = ST_I_M3;
            end
            ST_I_M3: begin
                o_cmd.op = OP_I_M3;
                n_state  = ST_I_SUB;
            end
            ST_I_SUB: begin
                o_cmd.op = OP_I_SUB;
                n_state  = ST_R2_UPD;
            end
            ST_R2_UPD: begin
                o_cmd.op = OP_R2_UPD;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                // hold while the previous item still sits stalled in the output
                if (!r_out_valid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.load_out || (r_out_valid && i_stall);
    assign o_valid     = r_out_valid;
    assign o_stall     = (r_state != ST_IDLE);

endmodule

### sv/midpoint_ellipse_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Axis-aligned midpoint ellipse rasterizer with APB-programmed semi-axes.
//
// Input channel (i_valid / o_stall): func 0 starts an ellipse at the given
// center and answers the four mirrored points of offset (0, b); func 1
// advances one midpoint step. Every item gives exactly one output item
// (o_valid / i_stall) carrying the four mirrored coordinates and last.
// A start, a region-one step, a steady region-two step and the step that
// enters region two each walk their own sequence of sequencer states; an
// advance after last goes straight to the output. The next item is taken
// in the cycle after the output is loaded. The step length is set by the
// single shared multiplier, used for one product of the step per state.
// The output register lets one finished item wait while the next is worked;
// a stalled output holds its payload, and a further result waits for it.
// Reset clears the step state to a finished ellipse at center zero and sets
// the semi-axes to 60 and 40. Write the semi-axes only while idle.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input items
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_func,
    input  logic [mer_pkg::COORD_BITS-1:0]        i_center_x,
    input  logic [mer_pkg::COORD_BITS-1:0]        i_center_y,
    // output items
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [mer_pkg::OUT_BITS-1:0]   o_px_right,
    output logic signed [mer_pkg::OUT_BITS-1:0]   o_px_left,
    output logic signed [mer_pkg::OUT_BITS-1:0]   o_py_top,
    output logic signed [mer_pkg::OUT_BITS-1:0]   o_py_bottom,
    output logic                                  o_last,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mer_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [mer_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [mer_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);
    import mer_pkg::*;

    logic [AXIS_BITS-1:0] r_semi_axis_x;
    logic [AXIS_BITS-1:0] r_semi_axis_y;
    t_reg_idx             w_reg_idx;
    logic                 w_wr;
    t_dp_cmd              w_cmd;
    t_dp_status           w_status;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[2]);
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_semi_axis_x <= AXIS_X_RESET;
            r_semi_axis_y <= AXIS_Y_RESET;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_SEMI_AXIS_X: r_semi_axis_x <= pwdata[AXIS_BITS-1:0];
                REG_SEMI_AXIS_Y: r_semi_axis_y <= pwdata[AXIS_BITS-1:0];
                default:         r_semi_axis_x <= r_semi_axis_x;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_SEMI_AXIS_X: prdata = APB_DATA_W'(r_semi_axis_x);
            REG_SEMI_AXIS_Y: prdata = APB_DATA_W'(r_semi_axis_y);
            default:         prdata = '0;
        endcase
    end

    mer_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    mer_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_semi_axis_x (r_semi_axis_x),
        .i_semi_axis_y (r_semi_axis_y),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .o_px_right    (o_px_right),
        .o_px_left     (o_px_left),
        .o_py_top      (o_py_top),
        .o_py_bottom   (o_py_bottom),
        .o_last        (o_last)
    );

endmodule
